@@ hdl/mt_pkg.sv @@
`timescale 1ns / 1ps

package mt_pkg;

    localparam int STATE_DEPTH  = 624;
    localparam int SHIFT_OFFSET = 397;
    localparam int ADDR_W       = 10;
    localparam int WORD_W       = 32;

    localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908b0df;
    localparam logic [WORD_W-1:0] HIGH_BIT     = 32'h80000000;
    localparam logic [WORD_W-1:0] LOW_BITS     = 32'h7fffffff;
    localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c5680;
    localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc60000;
    localparam logic [WORD_W-1:0] LCG_MULT     = 32'd69069;
    localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd4357;
    localparam logic [WORD_W-1:0] HALF_MASK    = 32'hffff0000;

    // two LCG steps folded into one: s2 = s * MULT^2 + (MULT + 1)
    localparam logic [63:0]       LCG_MULT_SQ  = 64'(LCG_MULT) * 64'(LCG_MULT);
    localparam logic [WORD_W-1:0] LCG_MULT2    = LCG_MULT_SQ[WORD_W-1:0];
    localparam logic [WORD_W-1:0] LCG_ADD2     = LCG_MULT + 32'd1;

    // position codes
    localparam logic [ADDR_W-1:0] POS_TWIST    = ADDR_W'(STATE_DEPTH);
    localparam logic [ADDR_W-1:0] POS_UNSEEDED = ADDR_W'(STATE_DEPTH + 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR    = ADDR_W'(STATE_DEPTH - 1);
    localparam logic [ADDR_W-1:0] FAR_OFFSET   = ADDR_W'(SHIFT_OFFSET);
    localparam logic [ADDR_W-1:0] FAR_WRAP     = ADDR_W'(STATE_DEPTH - SHIFT_OFFSET);

    localparam int FUNC_W = 2;
    localparam logic [FUNC_W-1:0] FUNC_GEN  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SEED = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_PRIME,
        ST_TWIST,
        ST_GEN_RD,
        ST_GEN_OUT
    } seq_state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [WORD_W-1:0] wdata;
        logic              re_a;
        logic [ADDR_W-1:0] raddr_a;
        logic              re_b;
        logic [ADDR_W-1:0] raddr_b;
    } mem_req_t;

    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] y_in);
        logic [WORD_W-1:0] y;
        y = y_in;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

@@ hdl/mersenne_twister_generator.sv @@
`timescale 1ns / 1ps
// Generate: the word is read from the state RAM, tempered and held in the output register;
//   a twist runs first when one is due, after a seeding with the default seed when unseeded.
// Load, seed and generate items are taken one at a time, only while the sequencer is idle.
// Twist speed is set by the state RAM: one word per cycle over two read ports.
// Reset clears control only: position marks "never seeded", state RAM is undefined.

module mersenne_twister_generator
    import mt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // func[1:0], value[33:2] (seed or load word), word_index[43:34], zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // random_word[31:0]
);

    logic              res_valid;
    logic              res_ready;
    logic [WORD_W-1:0] res_word;
    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] out_data_reg, out_data_next;
    logic              out_load;

    // core: command sequencer around the state RAM
    mt_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (s_tvalid),
        .cmd_ready (s_tready),
        .cmd_func  (s_tdata[1:0]),
        .cmd_value (s_tdata[33:2]),
        .cmd_index (s_tdata[43:34]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_word  (res_word)
    );

    // output register: take a new word when empty or being drained this cycle
    assign res_ready = !out_valid_reg || m_tready;
    assign out_load  = res_valid && res_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = temper(res_word);
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ hdl/mt_state_mem.sv @@
`timescale 1ns / 1ps

module mt_state_mem
    import mt_pkg::*;
(
    input  logic              clk,
    input  mem_req_t          req,
    output logic [WORD_W-1:0] rdata_a,
    output logic [WORD_W-1:0] rdata_b
);

    logic [WORD_W-1:0] mem [STATE_DEPTH];
    logic [WORD_W-1:0] rdata_a_reg;
    logic [WORD_W-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // read data holds while its port is not enabled
    always_ff @(posedge clk)
    begin
        if (req.re_a)
        begin
            rdata_a_reg <= mem[req.raddr_a];
        end
        if (req.re_b)
        begin
            rdata_b_reg <= mem[req.raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

@@ hdl/mt_seq.sv @@
`timescale 1ns / 1ps

module mt_seq
    import mt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  logic [FUNC_W-1:0] cmd_func,
    input  logic [WORD_W-1:0] cmd_value,
    input  logic [ADDR_W-1:0] cmd_index,
    output logic              res_valid,
    input  logic              res_ready,
    output logic [WORD_W-1:0] res_word
);

    seq_state_t        state_reg, state_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic [WORD_W-1:0] lcg_reg, lcg_next;
    logic              gen_after_reg, gen_after_next;
    logic              prime_reg, prime_next;
    logic              twist_rd_reg, twist_rd_next;
    logic [ADDR_W-1:0] wr_idx_reg, wr_idx_next;
    logic [WORD_W-1:0] cur_reg, cur_next;

    mem_req_t          req;
    logic [WORD_W-1:0] rdata_a;
    logic [WORD_W-1:0] rdata_b;

    logic [WORD_W-1:0] lcg_step1;
    logic [WORD_W-1:0] lcg_step2;
    logic [WORD_W-1:0] twist_y;
    logic [WORD_W-1:0] twist_v;
    logic              cmd_fire;

    mt_state_mem u_mem (
        .clk     (clk),
        .req     (req),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    assign lcg_step1 = lcg_reg * LCG_MULT + 32'd1;
    assign lcg_step2 = lcg_reg * LCG_MULT2 + LCG_ADD2;

    assign twist_y = (cur_reg & HIGH_BIT) | (rdata_a & LOW_BITS);
    assign twist_v = rdata_b ^ (twist_y >> 1) ^ (twist_y[0] ? TWIST_MATRIX : '0);

    assign cmd_ready = (state_reg == ST_IDLE);
    assign cmd_fire  = cmd_valid && cmd_ready;
    assign res_word  = rdata_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pos_reg      <= POS_UNSEEDED;
            cnt_reg      <= '0;
            gen_after_reg <= 1'b0;
            prime_reg    <= 1'b0;
            twist_rd_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            cnt_reg      <= cnt_next;
            gen_after_reg <= gen_after_next;
            prime_reg    <= prime_next;
            twist_rd_reg <= twist_rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lcg_reg    <= lcg_next;
        wr_idx_reg <= wr_idx_next;
        cur_reg    <= cur_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        lcg_next       = lcg_reg;
        gen_after_next = gen_after_reg;
        prime_next     = 1'b0;
        twist_rd_next  = 1'b0;
        wr_idx_next    = wr_idx_reg;
        cur_next       = cur_reg;
        res_valid      = 1'b0;
        req            = '0;

        // twist write-back for the word whose reads came back this cycle
        if (prime_reg || twist_rd_reg)
        begin
            cur_next = rdata_a;
        end
        if (twist_rd_reg)
        begin
            req.we    = 1'b1;
            req.waddr = wr_idx_reg;
            req.wdata = twist_v;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    case (cmd_func)
                        FUNC_SEED:
                        begin
                            lcg_next       = cmd_value;
                            cnt_next       = '0;
                            gen_after_next = 1'b0;
                            state_next     = ST_SEED;
                        end
                        FUNC_LOAD:
                        begin
                            if (cmd_index < POS_TWIST)
                            begin
                                req.we    = 1'b1;
                                req.waddr = cmd_index;
                                req.wdata = cmd_value;
                                pos_next  = POS_TWIST;
                            end
                        end
                        FUNC_GEN:
                        begin
                            if (pos_reg == POS_UNSEEDED)
                            begin
                                lcg_next       = DEFAULT_SEED;
                                cnt_next       = '0;
                                gen_after_next = 1'b1;
                                state_next     = ST_SEED;
                            end
                            else if (pos_reg == POS_TWIST)
                            begin
                                state_next = ST_PRIME;
                            end
                            else
                            begin
                                req.re_a    = 1'b1;
                                req.raddr_a = pos_reg;
                                pos_next    = pos_reg + 1'b1;
                                state_next  = ST_GEN_OUT;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SEED:
            begin
                // one word per cycle: high half from s, low half from the high half of s*MULT+1
                req.we    = 1'b1;
                req.waddr = cnt_reg;
                req.wdata = (lcg_reg & HALF_MASK) | ((lcg_step1 & HALF_MASK) >> 16);
                lcg_next  = lcg_step2;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == LAST_ADDR)
                begin
                    pos_next   = POS_TWIST;
                    state_next = gen_after_reg ? ST_PRIME : ST_IDLE;
                end
            end
            ST_PRIME:
            begin
                // fetch the old word 0 ahead of the first twist step
                req.re_a    = 1'b1;
                req.raddr_a = '0;
                prime_next  = 1'b1;
                cnt_next    = '0;
                state_next  = ST_TWIST;
            end
            ST_TWIST:
            begin
                if (cnt_reg < POS_TWIST)
                begin
                    req.re_a      = 1'b1;
                    req.raddr_a   = (cnt_reg == LAST_ADDR) ? '0 : cnt_reg + 1'b1;
                    req.re_b      = 1'b1;
                    req.raddr_b   = (cnt_reg < FAR_WRAP) ? cnt_reg + FAR_OFFSET
                                                         : cnt_reg - FAR_WRAP;
                    twist_rd_next = 1'b1;
                    wr_idx_next   = cnt_reg;
                    cnt_next      = cnt_reg + 1'b1;
                end
                if (twist_rd_reg && (wr_idx_reg == LAST_ADDR))
                begin
                    pos_next   = '0;
                    state_next = ST_GEN_RD;
                end
            end
            ST_GEN_RD:
            begin
                req.re_a    = 1'b1;
                req.raddr_a = pos_reg;
                pos_next    = pos_reg + 1'b1;
                state_next  = ST_GEN_OUT;
            end
            ST_GEN_OUT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        req.we |-> (req.waddr < POS_TWIST))
        else $error("state write beyond depth");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_UNSEEDED)
        else $error("position out of range");

    a_twist_end_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (twist_rd_reg && (wr_idx_reg == LAST_ADDR)) |=> (pos_reg == '0))
        else $error("position not rewound after twist");

    a_gen_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GEN_OUT) |-> (pos_reg != '0) && (pos_reg <= POS_TWIST))
        else $error("result shown without a consumed position");

endmodule
